@@ rtl/per_band_pulse_segmenter_core_macros.svh @@
// Assertion macros used by the pulse segmenter core
`ifndef PER_BAND_PULSE_SEGMENTER_CORE_MACROS_SVH
`define PER_BAND_PULSE_SEGMENTER_CORE_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define PBPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbps same-cycle check failed");

// next-cycle implication, checked on clk outside reset
`define PBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbps next-cycle check failed");

`endif

@@ rtl/pbps_pkg.sv @@
// Types, constants and helpers of the per-band pulse segmenter
package pbps_pkg;

  localparam int NUM_BANDS = 16;
  localparam int BAND_W    = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int REQ_DEPTH = 4;
  localparam int REQ_PTR_W = $clog2(REQ_DEPTH);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MIN_AMP     = 3'd0,
    CFG_MAX_AMP     = 3'd1,
    CFG_BANDS       = 3'd2,
    CFG_MAX_GAP     = 3'd3,
    CFG_MIN_SAMPLES = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  band;
    logic [31:0] sample_index;
    logic [15:0] amplitude;
    logic [35:0] frequency_hz;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  pulse_band;
    logic [31:0] first_index;
    logic [31:0] last_index;
    logic [15:0] peak_amplitude;
    logic [15:0] sample_count;
    logic [35:0] peak_frequency_hz;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_amplitude;
    logic [15:0] max_amplitude;
    logic [4:0]  bands_in_use;
    logic [15:0] max_gap_samples;
    logic [15:0] min_samples_per_pulse;
  } cfg_t;

  typedef struct packed {
    logic              flush;
    logic [BAND_W-1:0] band;
    logic [31:0]       idx;
    logic [15:0]       amp;
    logic [35:0]       freq;
  } req_t;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] latest;
    logic [15:0] peak;
    logic [15:0] count;
    logic [35:0] freq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic idle;
    logic flushing;
  } back_stat_t;

  function automatic entry_t open_entry(req_t r);
    entry_t e;
    e.first  = r.idx;
    e.latest = r.idx;
    e.peak   = r.amp;
    e.count  = 16'd1;
    e.freq   = r.freq;
    return e;
  endfunction

  function automatic out_item_t make_result(logic [BAND_W-1:0] b, entry_t e, logic lst);
    out_item_t o;
    o.pulse_band        = 6'(b);
    o.first_index       = e.first;
    o.last_index        = e.latest;
    o.peak_amplitude    = e.peak;
    o.sample_count      = e.count;
    o.peak_frequency_hz = e.freq;
    o.last              = lst;
    return o;
  endfunction

endpackage

@@ rtl/per_band_pulse_segmenter_core.sv @@
// Top level of the per-band pulse segmenter: config registers, front, queue, back
// Usage:
//   Input side is a queue write port: an item (sample or flush) is taken on a
//   clock edge with push high and full low. Samples outside the amplitude
//   window or in an unused band are taken and discarded at once.
//   Result side is a queue read port: while empty is low the oldest pulse
//   descriptor is on out_data; it is taken on an edge with pop high.
//   Config registers are written through cfg_we/cfg_addr/cfg_wdata, one per
//   cycle; the user must do so only while no item is in flight (unchecked).
// Flow:
//   A four-entry request queue separates the front end from the back end.
//   A sample to a band with no open pulse is written in the idle state; one
//   to a band with an open pulse takes a state RAM read, then update/write.
//   A flush is a one-band-at-a-time sweep over the state RAM. A closing
//   sample's result is registered in the update step; a flush's final one
//   in the end state after the sweep.
// Reset (rst_n low, synchronous): all pulses closed, queues emptied, config
//   back to its defaults. A stalled receiver holds the result register; a
//   back end with another result waits; the queue fills until full rises.
`include "per_band_pulse_segmenter_core_macros.svh"

module per_band_pulse_segmenter_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  pbps_pkg::in_item_t                   in_data,
  output logic                                 empty,
  input  logic                                 pop,
  output pbps_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [pbps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [pbps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  pbps_pkg::cfg_t       cfg_r;
  logic                 q_push;
  pbps_pkg::req_t       q_req;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  pbps_pkg::req_t       q_head;
  logic                 out_valid;
  pbps_pkg::back_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_amplitude         <= 16'd0;
      cfg_r.max_amplitude         <= 16'hFFFF;
      cfg_r.bands_in_use          <= 5'd16;
      cfg_r.max_gap_samples       <= 16'd1;
      cfg_r.min_samples_per_pulse <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pbps_pkg::CFG_MIN_AMP:     cfg_r.min_amplitude         <= cfg_wdata;
        pbps_pkg::CFG_MAX_AMP:     cfg_r.max_amplitude         <= cfg_wdata;
        pbps_pkg::CFG_BANDS:       cfg_r.bands_in_use          <= cfg_wdata[4:0];
        pbps_pkg::CFG_MAX_GAP:     cfg_r.max_gap_samples       <= cfg_wdata;
        pbps_pkg::CFG_MIN_SAMPLES: cfg_r.min_samples_per_pulse <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pbps_front u_front (
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_req   (q_req)
  );

  pbps_req_fifo u_req_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_req   (q_req),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  pbps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .pop       (pop),
    .stat      (stat)
  );

  assign empty = !out_valid;

  `PBPS_ASSERT_SAME(a_pop_only_idle, q_pop, stat.idle && !q_empty)
  `PBPS_ASSERT_SAME(a_no_push_full, q_full, !q_push)
  `PBPS_ASSERT_NEXT(a_flush_starts, q_pop && q_head.flush, stat.flushing)
  `PBPS_ASSERT_NEXT(a_queue_holds, !q_empty && !q_pop, !q_empty)

endmodule

@@ rtl/pbps_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module pbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pbps_front.sv @@
// Front end: accept input items, drop out-of-window and unused-band samples, build requests
module pbps_front (
  input  logic              push,
  output logic              full,
  input  pbps_pkg::in_item_t in_data,
  input  pbps_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output pbps_pkg::req_t    q_req
);

  logic amp_ok;
  logic band_ok;
  logic keep;

  assign amp_ok  = (in_data.amplitude >= cfg.min_amplitude) &&
                   (in_data.amplitude <= cfg.max_amplitude);
  assign band_ok = (in_data.band < {1'b0, cfg.bands_in_use}) &&
                   ({1'b0, in_data.band} < 7'(pbps_pkg::NUM_BANDS));
  assign keep    = (in_data.cmd == pbps_pkg::CMD_FLUSH) || (amp_ok && band_ok);

  assign full   = q_full;
  assign q_push = push && !q_full && keep;

  always_comb begin
    q_req       = '0;
    q_req.flush = (in_data.cmd == pbps_pkg::CMD_FLUSH);
    q_req.band  = in_data.band[pbps_pkg::BAND_W-1:0];
    q_req.idx   = in_data.sample_index;
    q_req.amp   = in_data.amplitude;
    q_req.freq  = in_data.frequency_hz;
  end

endmodule

@@ rtl/pbps_req_fifo.sv @@
// Request queue between front end and back end
module pbps_req_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  pbps_pkg::req_t q_req,
  input  logic           q_pop,
  output logic           q_full,
  output logic           q_empty,
  output pbps_pkg::req_t q_head
);

  pbps_pkg::req_t                  mem_r [pbps_pkg::REQ_DEPTH];
  logic [pbps_pkg::REQ_PTR_W-1:0]  wr_ptr_r;
  logic [pbps_pkg::REQ_PTR_W-1:0]  rd_ptr_r;
  logic [pbps_pkg::REQ_PTR_W:0]    count_r;
  logic                            do_push;
  logic                            do_pop;

  assign q_full  = (count_r == (pbps_pkg::REQ_PTR_W + 1)'(pbps_pkg::REQ_DEPTH));
  assign q_empty = (count_r == '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_req;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/pbps_back.sv @@
// Back end: per-band pulse state, sample update, flush sweep and result register
module pbps_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbps_pkg::cfg_t        cfg,
  input  logic                  q_empty,
  input  pbps_pkg::req_t        q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  output pbps_pkg::out_item_t   out_data,
  input  logic                  pop,
  output pbps_pkg::back_stat_t  stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SMP,
    ST_FRD,
    ST_FCHK,
    ST_FEND
  } state_t;

  state_t                          state_r, state_nxt;
  pbps_pkg::req_t                  req_r, req_nxt;
  logic [pbps_pkg::NUM_BANDS-1:0]  open_r, open_nxt;
  logic [pbps_pkg::BAND_W-1:0]     cnt_r, cnt_nxt;
  logic                            pend_v_r, pend_v_nxt;
  pbps_pkg::out_item_t             pend_r, pend_nxt;
  logic                            out_v_r, out_v_nxt;
  pbps_pkg::out_item_t             out_r, out_nxt;

  logic                            ram_we;
  logic [pbps_pkg::BAND_W-1:0]     ram_waddr;
  logic [pbps_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [pbps_pkg::BAND_W-1:0]     ram_raddr;
  logic [pbps_pkg::ENTRY_W-1:0]    ram_rdata;

  pbps_pkg::entry_t                ent;
  pbps_pkg::entry_t                ext;
  logic [31:0]                     step;
  logic [15:0]                     gap_eff;
  logic                            out_free;
  logic                            qual;

  pbps_ram #(
    .WIDTH (pbps_pkg::ENTRY_W),
    .DEPTH (pbps_pkg::NUM_BANDS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent      = pbps_pkg::entry_t'(ram_rdata);
  assign gap_eff  = (cfg.max_gap_samples == '0) ? 16'd1 : cfg.max_gap_samples;
  assign step     = req_r.idx - ent.latest;
  assign out_free = !out_v_r || pop;
  assign qual     = open_r[cnt_r] && (ent.count >= cfg.min_samples_per_pulse);

  always_comb begin
    ext        = ent;
    ext.latest = req_r.idx;
    if (ent.count != 16'hFFFF) begin
      ext.count = ent.count + 16'd1;
    end
    if (req_r.amp > ent.peak) begin
      ext.peak = req_r.amp;
      ext.freq = req_r.freq;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    open_nxt   = open_r;
    cnt_nxt    = cnt_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = req_r.band;
    ram_wdata  = ext;
    ram_raddr  = req_r.band;

    if (out_v_r && pop) begin
      out_v_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = q_head.band;
        if (!q_empty) begin
          q_pop   = 1'b1;
          req_nxt = q_head;
          if (q_head.flush) begin
            cnt_nxt   = '0;
            state_nxt = ST_FRD;
          end else if (open_r[q_head.band]) begin
            state_nxt = ST_SMP;
          end else begin
            ram_we               = 1'b1;
            ram_waddr            = q_head.band;
            ram_wdata            = pbps_pkg::open_entry(q_head);
            open_nxt[q_head.band] = 1'b1;
          end
        end
      end
      ST_SMP: begin
        if (step <= {16'd0, gap_eff}) begin
          ram_we    = 1'b1;
          ram_wdata = ext;
          state_nxt = ST_IDLE;
        end else if (ent.count >= cfg.min_samples_per_pulse) begin
          if (out_free) begin
            out_v_nxt = 1'b1;
            out_nxt   = pbps_pkg::make_result(req_r.band, ent, 1'b1);
            ram_we    = 1'b1;
            ram_wdata = pbps_pkg::open_entry(req_r);
            state_nxt = ST_IDLE;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = pbps_pkg::open_entry(req_r);
          state_nxt = ST_IDLE;
        end
      end
      ST_FRD: begin
        ram_raddr = cnt_r;
        state_nxt = ST_FCHK;
      end
      ST_FCHK: begin
        ram_raddr = cnt_r;
        if (!qual || !pend_v_r || out_free) begin
          if (qual && pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = pend_r;
          end
          if (qual) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = pbps_pkg::make_result(cnt_r, ent, 1'b0);
          end
          open_nxt[cnt_r] = 1'b0;
          if (cnt_r == pbps_pkg::BAND_W'(pbps_pkg::NUM_BANDS - 1)) begin
            state_nxt = ST_FEND;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_FRD;
          end
        end
      end
      ST_FEND: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt     = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      open_r   <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      open_r   <= open_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_data      = out_r;
  assign stat.idle     = (state_r == ST_IDLE);
  assign stat.flushing = (state_r == ST_FRD) || (state_r == ST_FCHK) || (state_r == ST_FEND);

endmodule
